@@ rtl/eowm_pkg.sv @@
// Shared types and constants of the eight-opcode word machine core.
// Holds command and opcode codes, engine states, field positions and the
// register-file request struct. Depends on nothing.
package eowm_pkg;

    // Default memory depth. The depth must be a power of two so that
    // address and pc wrap reduce to dropping the upper bits.
    localparam int MEM_WORDS_DEF = 65536;
    localparam int REG_COUNT     = 8;
    localparam int RIDX_W        = 3;
    localparam int WORD_W        = 32;
    localparam int ADDR_FIELD_W  = 16;
    localparam int CMD_W         = 2;

    // Stream packing.
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (WORD_W + ADDR_FIELD_W + 1 + WORD_W);

    // Instruction word fields.
    localparam int OP_LSB  = 22;
    localparam int RA_LSB  = 19;
    localparam int RB_LSB  = 16;
    localparam int OFF_W   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD     = 2'd0,
        CMD_EXEC     = 2'd1,
        CMD_READ_MEM = 2'd2,
        CMD_READ_REG = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_NOR  = 3'd1,
        OP_LW   = 3'd2,
        OP_SW   = 3'd3,
        OP_BEQ  = 3'd4,
        OP_JALR = 3'd5,
        OP_HALT = 3'd6,
        OP_NOOP = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_FETCH = 3'd1,
        ST_EXEC  = 3'd2,
        ST_LOAD  = 3'd3,
        ST_RDMEM = 3'd4,
        ST_RDREG = 3'd5
    } t_state;

    typedef struct packed {
        logic              we;
        logic [RIDX_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [RIDX_W-1:0] raddr_a;
        logic [RIDX_W-1:0] raddr_b;
    } t_rf_req;

    function automatic logic [WORD_W-1:0] sext_off(input logic [OFF_W-1:0] off);
        sext_off = {{(WORD_W - OFF_W){off[OFF_W-1]}}, off};
    endfunction

endpackage

@@ rtl/eowm_rf.sv @@
// Register file of the word machine: eight words, one write and two
// registered read ports. Depends on eowm_pkg.
module eowm_rf (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  eowm_pkg::t_rf_req                 i_req,
    output logic [eowm_pkg::WORD_W-1:0]       o_qa,
    output logic [eowm_pkg::WORD_W-1:0]       o_qb
);

    logic [eowm_pkg::WORD_W-1:0]    r_mem [eowm_pkg::REG_COUNT];
    logic [eowm_pkg::REG_COUNT-1:0] r_vld;

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_qa <= r_vld[i_req.raddr_a] ? r_mem[i_req.raddr_a] : '0;
            o_qb <= r_vld[i_req.raddr_b] ? r_mem[i_req.raddr_b] : '0;
        end
    end

endmodule

@@ rtl/eight_opcode_word_machine_core.sv @@
// Top level of the eight-opcode word machine core: input buffer, command
// sequencer, word memory and result register. Depends on eowm_pkg, eowm_rf.
//
// Usage. Commands arrive as beats on the slave stream: tuser carries the
// command (load word, execute, read memory, read register) and tdata the
// address and data. Every command beat yields exactly one result beat on
// the master stream with the word read (zero for load and execute), the
// pc, the halted flag and the number of executed instructions.
//
// Timing. The word memory is one single-port synchronous memory with
// registered read data; pc, halt flag and count are registers. A load word
// completes in the cycle it leaves the input buffer. A read passes through
// its read state, an executed instruction through fetch, register read and
// execute, and a load instruction adds a load step for its data read
// from the same memory port. An execute after halt completes in the cycle
// it leaves the input buffer. The result is registered.
//
// The input buffer takes the next beat while the current one is at work.
// A command starts only when the result register is empty or its beat is
// taken in that cycle, so a command never waits once started. When the
// receiver stalls, the result holds and the sequencer waits before
// starting a new command; the input side backs up.
// Synchronous reset clears the registers, pc, halt flag, count and all
// handshake state; memory contents are undefined until written.
module eight_opcode_word_machine_core #(
    parameter int MEM_WORDS = eowm_pkg::MEM_WORDS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // address [15:0], data [47:16]
    input  logic [eowm_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // command [1:0]
    input  logic [eowm_pkg::CMD_W-1:0]           i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // read_data [31:0], program_counter [47:32], halted [48],
    // executed_count [80:49], zero [87:81]
    output logic [eowm_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int WW = eowm_pkg::WORD_W;
    localparam int RW = eowm_pkg::RIDX_W;

    // Input buffer.
    logic                              r_in_vld;
    eowm_pkg::t_cmd                    r_in_cmd;
    logic [eowm_pkg::ADDR_FIELD_W-1:0] r_in_addr;
    logic [WW-1:0]                     r_in_data;

    // Architectural state outside the memories.
    eowm_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_pc, n_pc;
    logic             r_halt, n_halt;
    logic [WW-1:0]    r_cnt, n_cnt;
    logic [WW-1:0]    r_inst;

    // Result register.
    logic          r_out_vld;
    logic [WW-1:0] r_out_rdata;
    logic [AW-1:0] r_out_pc;
    logic          r_out_halt;
    logic [WW-1:0] r_out_cnt;

    // Word memory port.
    logic [WW-1:0] r_mem [MEM_WORDS];
    logic [WW-1:0] r_mem_q;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    logic [WW-1:0] mem_wdata;

    eowm_pkg::t_rf_req rf_req;
    logic [WW-1:0]     rf_qa, rf_qb;

    logic          slot_free, take, s_beat, done, inst_ld;
    logic [WW-1:0] done_rdata;

    eowm_pkg::t_op op;
    logic [RW-1:0] ra, rb, rd;
    logic [WW-1:0] off32, pc_inc32, data_addr32, br_target32;

    // A new command starts only when its result will find the result
    // register free, so no later state ever has to wait on the output.
    assign slot_free  = !r_out_vld || i_m_tready;
    assign take       = (r_state == eowm_pkg::ST_IDLE) && r_in_vld && slot_free;
    assign o_s_tready = !r_in_vld || take;
    assign s_beat     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_beat) begin
            r_in_vld <= 1'b1;
        end else if (take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_in_cmd  <= eowm_pkg::t_cmd'(i_s_tuser);
            r_in_addr <= i_s_tdata[eowm_pkg::ADDR_FIELD_W-1:0];
            r_in_data <= i_s_tdata[eowm_pkg::IN_TDATA_W-1:eowm_pkg::ADDR_FIELD_W];
        end
    end

    // Single-port word memory, read data registered.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_addr];
        end
    end

    eowm_rf u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rf_req),
        .o_qa    (rf_qa),
        .o_qb    (rf_qb)
    );

    // Instruction decode from the latched word.
    assign op          = eowm_pkg::t_op'(r_inst[eowm_pkg::OP_LSB +: 3]);
    assign ra          = r_inst[eowm_pkg::RA_LSB +: RW];
    assign rb          = r_inst[eowm_pkg::RB_LSB +: RW];
    assign rd          = r_inst[RW-1:0];
    assign off32       = eowm_pkg::sext_off(r_inst[eowm_pkg::OFF_W-1:0]);
    assign pc_inc32    = WW'(r_pc) + WW'(1);
    assign data_addr32 = rf_qa + off32;
    assign br_target32 = pc_inc32 + off32;

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_halt     = r_halt;
        n_cnt      = r_cnt;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = r_pc;
        mem_wdata  = rf_qb;
        rf_req     = '0;
        done       = 1'b0;
        done_rdata = '0;
        inst_ld    = 1'b0;
        unique case (r_state)
            eowm_pkg::ST_IDLE: begin
                if (take) begin
                    unique case (r_in_cmd)
                        eowm_pkg::CMD_LOAD: begin
                            mem_we    = 1'b1;
                            mem_addr  = r_in_addr[AW-1:0];
                            mem_wdata = r_in_data;
                            done      = 1'b1;
                        end
                        eowm_pkg::CMD_EXEC: begin
                            if (r_halt) begin
                                done = 1'b1;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = eowm_pkg::ST_FETCH;
                            end
                        end
                        eowm_pkg::CMD_READ_MEM: begin
                            mem_re   = 1'b1;
                            mem_addr = r_in_addr[AW-1:0];
                            n_state  = eowm_pkg::ST_RDMEM;
                        end
                        eowm_pkg::CMD_READ_REG: begin
                            rf_req.re      = 1'b1;
                            rf_req.raddr_a = r_in_addr[RW-1:0];
                            n_state        = eowm_pkg::ST_RDREG;
                        end
                    endcase
                end
            end
            eowm_pkg::ST_FETCH: begin
                inst_ld        = 1'b1;
                rf_req.re      = 1'b1;
                rf_req.raddr_a = r_mem_q[eowm_pkg::RA_LSB +: RW];
                rf_req.raddr_b = r_mem_q[eowm_pkg::RB_LSB +: RW];
                n_state        = eowm_pkg::ST_EXEC;
            end
            eowm_pkg::ST_EXEC: begin
                n_cnt   = r_cnt + WW'(1);
                n_pc    = pc_inc32[AW-1:0];
                n_state = eowm_pkg::ST_IDLE;
                done    = 1'b1;
                unique case (op)
                    eowm_pkg::OP_ADD: begin
                        rf_req.we    = 1'b1;
                        rf_req.waddr = rd;
                        rf_req.wdata = rf_qa + rf_qb;
                    end
                    eowm_pkg::OP_NOR: begin
                        rf_req.we    = 1'b1;
                        rf_req.waddr = rd;
                        rf_req.wdata = ~(rf_qa | rf_qb);
                    end
                    eowm_pkg::OP_LW: begin
                        mem_re   = 1'b1;
                        mem_addr = data_addr32[AW-1:0];
                        n_state  = eowm_pkg::ST_LOAD;
                        done     = 1'b0;
                    end
                    eowm_pkg::OP_SW: begin
                        mem_we   = 1'b1;
                        mem_addr = data_addr32[AW-1:0];
                    end
                    eowm_pkg::OP_BEQ: begin
                        if (rf_qa == rf_qb) begin
                            n_pc = br_target32[AW-1:0];
                        end
                    end
                    eowm_pkg::OP_JALR: begin
                        // The link is written first, so a target register
                        // equal to the link register jumps to pc + 1.
                        rf_req.we    = 1'b1;
                        rf_req.waddr = rb;
                        rf_req.wdata = pc_inc32;
                        if (ra != rb) begin
                            n_pc = rf_qa[AW-1:0];
                        end
                    end
                    eowm_pkg::OP_HALT: begin
                        n_halt = 1'b1;
                    end
                    eowm_pkg::OP_NOOP: begin
                    end
                endcase
            end
            eowm_pkg::ST_LOAD: begin
                rf_req.we    = 1'b1;
                rf_req.waddr = rb;
                rf_req.wdata = r_mem_q;
                done         = 1'b1;
                n_state      = eowm_pkg::ST_IDLE;
            end
            eowm_pkg::ST_RDMEM: begin
                done_rdata = r_mem_q;
                done       = 1'b1;
                n_state    = eowm_pkg::ST_IDLE;
            end
            eowm_pkg::ST_RDREG: begin
                done_rdata = rf_qa;
                done       = 1'b1;
                n_state    = eowm_pkg::ST_IDLE;
            end
            default: begin
                n_state = eowm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eowm_pkg::ST_IDLE;
            r_pc    <= '0;
            r_halt  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_halt  <= n_halt;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (inst_ld) begin
            r_inst <= r_mem_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (done) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    // The result reports the state after the command.
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_rdata <= done_rdata;
            r_out_pc    <= n_pc;
            r_out_halt  <= n_halt;
            r_out_cnt   <= n_cnt;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{eowm_pkg::OUT_PAD_W{1'b0}}, r_out_cnt, r_out_halt,
                         eowm_pkg::ADDR_FIELD_W'(r_out_pc), r_out_rdata};

endmodule

@@ rtl/eowm_chk.sv @@
// Port-level checker of the word machine core and its bind statement.
// Depends on eight_opcode_word_machine_core and eowm_pkg.
module eowm_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               i_s_tready,
    input logic                               i_m_tvalid,
    input logic                               i_m_tready,
    input logic [eowm_pkg::OUT_TDATA_W-1:0]   i_m_tdata
);

    logic        in_beat, out_beat;
    logic [1:0]  r_pend;
    logic        r_seen_halt;
    logic [15:0] r_last_pc;
    logic [31:0] r_last_cnt;

    assign in_beat  = i_s_tvalid && i_s_tready;
    assign out_beat = i_m_tvalid && i_m_tready;

    // Commands accepted but not yet answered; at most two can be inside.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_seen_halt <= 1'b0;
        end else begin
            r_pend <= r_pend + 2'(in_beat) - 2'(out_beat);
            if (out_beat && i_m_tdata[48]) begin
                r_seen_halt <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_beat) begin
            r_last_pc  <= i_m_tdata[47:32];
            r_last_cnt <= i_m_tdata[80:49];
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result changed");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> r_pend != 2'd0)
        else $error("result without a pending command");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_seen_halt |-> i_m_tdata[48])
        else $error("halted flag cleared");

    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_seen_halt |->
            i_m_tdata[47:32] == r_last_pc && i_m_tdata[80:49] == r_last_cnt)
        else $error("pc or count moved after halt");

endmodule

bind eight_opcode_word_machine_core eowm_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

@@ test/tb.sv @@
// Self-checking testbench for eight_opcode_word_machine_core. Needs eowm_pkg.
// Drives command beats on the slave stream, predicts result beats with an
// in-bench machine copy or a directed table, and checks the master stream.
module tb;
    import eowm_pkg::*;

    localparam int MEM_DEPTH   = MEM_WORDS_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PER_PHASE   = 580;
    localparam int N_DIRECTED  = 26;

    // One result beat as the block reports it.
    typedef struct packed {
        logic [WORD_W-1:0]       word;
        logic [ADDR_FIELD_W-1:0] pc;
        logic                    halted;
        logic [WORD_W-1:0]       count;
    } beat_t;

    // One row of the directed table. When typed is set, want is the
    // expected result; otherwise the prediction is used.
    typedef struct {
        t_cmd                    cmd;
        logic [ADDR_FIELD_W-1:0] addr;
        logic [WORD_W-1:0]       data;
        bit                      typed;
        beat_t                   want;
    } step_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic [CMD_W-1:0]       i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    // Copy of the machine state, advanced once per accepted command beat.
    logic [WORD_W-1:0]       gpr [REG_COUNT];
    logic [WORD_W-1:0]       word_mem [MEM_DEPTH];
    bit                      word_known [MEM_DEPTH];
    logic [ADDR_FIELD_W-1:0] known_addrs [$];
    logic [ADDR_FIELD_W-1:0] cur_pc = '0;
    logic                    is_halted = 1'b0;
    logic [WORD_W-1:0]       insn_count = '0;

    beat_t       expected_beats [$];
    int          mismatches = 0;
    int          issued_items = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          phase = 0;
    logic        rx_hold = 1'b0;
    int unsigned cycle_count = 0;

    step_row_t directed_steps [N_DIRECTED];

    eight_opcode_word_machine_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        foreach (gpr[i]) gpr[i] = '0;
    end

    // Builds an instruction word. For add and nor the low field carries the
    // destination register in its bottom three bits.
    function automatic logic [WORD_W-1:0] encode(t_op op, logic [2:0] ra, logic [2:0] rb,
                                                 logic [OFF_W-1:0] low);
        encode = '0;
        encode[OP_LSB +: 3] = op;
        encode[RA_LSB +: 3] = ra;
        encode[RB_LSB +: 3] = rb;
        encode[OFF_W-1:0]   = low;
    endfunction

    // Random instruction with random ignored bits. Halt is kept out so that
    // the machine keeps running until the closing sequence.
    function automatic logic [WORD_W-1:0] random_instruction();
        t_op              op;
        logic [OFF_W-1:0] low;
        op = t_op'($urandom_range(0, 7));
        if (op == OP_HALT) op = OP_NOOP;
        // Mostly short offsets so branches and data accesses stay near code.
        if ($urandom_range(0, 3) != 0) low = 16'($urandom_range(0, 16)) - 16'd8;
        else low = 16'($urandom);
        return encode(op, 3'($urandom), 3'($urandom), low) | ($urandom & 32'hFE00_0000);
    endfunction

    function automatic void mark_written(logic [ADDR_FIELD_W-1:0] addr, logic [WORD_W-1:0] val);
        word_mem[addr] = val;
        word_known[addr] = 1'b1;
        known_addrs.push_back(addr);
    endfunction

    // Advances the machine copy by one command and returns the result beat.
    function automatic beat_t apply_command(t_cmd cmd, logic [ADDR_FIELD_W-1:0] addr,
                                            logic [WORD_W-1:0] data);
        beat_t             r;
        logic [WORD_W-1:0] insn;
        logic [WORD_W-1:0] offset;
        logic [WORD_W-1:0] next_pc;
        logic [WORD_W-1:0] ea;
        logic [2:0]        ra;
        logic [2:0]        rb;
        r.word = '0;
        case (cmd)
            CMD_LOAD: begin
                mark_written(16'(addr % MEM_DEPTH), data);
            end
            CMD_EXEC: begin
                // After halt an execute changes nothing.
                if (!is_halted) begin
                    insn    = word_mem[cur_pc];
                    ra      = insn[RA_LSB +: 3];
                    rb      = insn[RB_LSB +: 3];
                    offset  = {{(WORD_W - OFF_W){insn[OFF_W-1]}}, insn[OFF_W-1:0]};
                    next_pc = 32'(cur_pc) + 32'd1;
                    ea      = gpr[ra] + offset;
                    insn_count = insn_count + 1;
                    case (t_op'(insn[OP_LSB +: 3]))
                        OP_ADD:  gpr[insn[2:0]] = gpr[ra] + gpr[rb];
                        OP_NOR:  gpr[insn[2:0]] = ~(gpr[ra] | gpr[rb]);
                        OP_LW:   gpr[rb] = word_mem[ea % MEM_DEPTH];
                        OP_SW:   mark_written(16'(ea % MEM_DEPTH), gpr[rb]);
                        OP_BEQ: begin
                            if (gpr[ra] == gpr[rb]) next_pc = 32'(cur_pc) + 32'd1 + offset;
                        end
                        OP_JALR: begin
                            // The link is written first, so ra == rb jumps to pc + 1.
                            gpr[rb] = 32'(cur_pc) + 32'd1;
                            next_pc = gpr[ra];
                        end
                        OP_HALT: is_halted = 1'b1;
                        default: ;
                    endcase
                    cur_pc = 16'(next_pc % MEM_DEPTH);
                end
            end
            CMD_READ_MEM: r.word = word_mem[addr % MEM_DEPTH];
            default:      r.word = gpr[addr[2:0]];
        endcase
        r.pc     = cur_pc;
        r.halted = is_halted;
        r.count  = insn_count;
        return r;
    endfunction

    // Offers one command beat after a random gap and waits for acceptance.
    task automatic issue_command(t_cmd cmd, logic [ADDR_FIELD_W-1:0] addr,
                                 logic [WORD_W-1:0] data, bit typed = 1'b0,
                                 beat_t typed_beat = '0);
        beat_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {data, addr};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = apply_command(cmd, addr, data);
        expected_beats.push_back(typed ? typed_beat : predicted);
        issued_items++;
    endtask

    function automatic void flag_mismatch(string field, logic [WORD_W-1:0] want,
                                          logic [WORD_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endfunction

    // Reset is held at the start and never again.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off in the last phase.
    always @(posedge i_clk) begin
        i_m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // The long hold-off lets the result register and input buffer fill so
    // the slave side must back up while the sender keeps offering beats.
    initial begin
        wait (phase == 2);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Checks every accepted result beat against the oldest expectation.
    always @(posedge i_clk) begin
        beat_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_beats.size() == 0) begin
                flag_mismatch("beat with nothing expected", '0, o_m_tdata[31:0]);
            end else begin
                want = expected_beats.pop_front();
                if (o_m_tdata[31:0] !== want.word)
                    flag_mismatch("read_data", want.word, o_m_tdata[31:0]);
                if (o_m_tdata[47:32] !== want.pc)
                    flag_mismatch("program_counter", 32'(want.pc), 32'(o_m_tdata[47:32]));
                if (o_m_tdata[48] !== want.halted)
                    flag_mismatch("halted", 32'(want.halted), 32'(o_m_tdata[48]));
                if (o_m_tdata[80:49] !== want.count)
                    flag_mismatch("executed_count", want.count, o_m_tdata[80:49]);
                if (o_m_tdata[OUT_TDATA_W-1:81] !== '0)
                    flag_mismatch("padding", '0, 32'(o_m_tdata[OUT_TDATA_W-1:81]));
            end
        end
    end

    initial begin
        logic [WORD_W-1:0]       insn;
        logic [WORD_W-1:0]       ea;
        logic [ADDR_FIELD_W-1:0] hop;
        int                      pick;
        int                      target;

        // Directed part. The small program exercises two loads, one with address
        // wrap, add overflow, nor, store, a taken and an untaken branch, a jalr
        // whose link and target register coincide, and a noop whose ignored upper
        // bits are all set.
        directed_steps = '{
            '{CMD_READ_REG, 16'hFFF8, 32'h0, 1'b1, '0},
            '{CMD_READ_REG, 16'h0007, 32'h0, 1'b1, '0},
            '{CMD_LOAD,     16'hFFFF, 32'h8000_0000, 1'b1, '0},
            '{CMD_READ_MEM, 16'hFFFF, 32'h0, 1'b1, '{word: 32'h8000_0000, default: '0}},
            '{CMD_LOAD,     16'h1234, 32'hFFFF_FFFF, 1'b1, '0},
            '{CMD_READ_MEM, 16'h1234, 32'h0, 1'b1, '{word: 32'hFFFF_FFFF, default: '0}},
            '{CMD_LOAD, 16'h0000, encode(OP_LW, 3'd0, 3'd1, 16'hFFFF), 1'b1, '0},
            '{CMD_LOAD, 16'h0001, encode(OP_LW, 3'd0, 3'd2, 16'h1234), 1'b1, '0},
            '{CMD_LOAD, 16'h0002, encode(OP_ADD, 3'd1, 3'd2, 16'd3), 1'b1, '0},
            '{CMD_LOAD, 16'h0003, encode(OP_NOR, 3'd1, 3'd0, 16'd4), 1'b1, '0},
            '{CMD_LOAD, 16'h0004, encode(OP_SW, 3'd0, 3'd3, 16'h0100), 1'b1, '0},
            '{CMD_LOAD, 16'h0005, encode(OP_BEQ, 3'd3, 3'd4, 16'd2), 1'b1, '0},
            '{CMD_LOAD, 16'h0008, encode(OP_BEQ, 3'd0, 3'd1, 16'h8000), 1'b1, '0},
            '{CMD_LOAD, 16'h0009, encode(OP_JALR, 3'd5, 3'd5, 16'h0), 1'b1, '0},
            '{CMD_LOAD, 16'h000A,
              encode(OP_NOOP, 3'd7, 3'd7, 16'hABCD) | 32'hFE00_0000, 1'b1, '0},
            '{CMD_EXEC, 16'h0000, 32'h0, 1'b0, '0},
            '{CMD_EXEC, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 32'h0, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 32'h0, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 32'h0, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 32'h0, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 32'h0, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 32'h0, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 32'h0, 1'b0, '0},
            '{CMD_READ_MEM, 16'h0100, 32'h0, 1'b0, '0},
            '{CMD_READ_REG, 16'h0005, 32'h0, 1'b0, '0}
        };

        while (!i_rst_n) @(posedge i_clk);

        // Phase 0: light sender gaps, heavy receiver stalls. Phase 1 swaps
        // them. Phase 2 runs without idling apart from the long hold-off.
        for (int ph = 0; ph < 3; ph++) begin
            phase = ph;
            tx_idle_pct <= (ph == 0) ? 8 : (ph == 1) ? 64 : 0;
            rx_idle_pct <= (ph == 0) ? 64 : (ph == 1) ? 8 : 0;
            if (ph == 0) begin
                foreach (directed_steps[i])
                    issue_command(directed_steps[i].cmd, directed_steps[i].addr,
                                  directed_steps[i].data, directed_steps[i].typed,
                                  directed_steps[i].want);
            end
            target = issued_items + PER_PHASE;
            while (issued_items < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    // Never fetch an unwritten word: place an instruction at
                    // pc first, and replace data words that decode as halt.
                    if (!word_known[cur_pc] || t_op'(word_mem[cur_pc][OP_LSB +: 3]) == OP_HALT)
                        issue_command(CMD_LOAD, cur_pc, random_instruction());
                    insn = word_mem[cur_pc];
                    // A load instruction must find its data word written.
                    if (t_op'(insn[OP_LSB +: 3]) == OP_LW) begin
                        ea = gpr[insn[RA_LSB +: 3]]
                           + {{(WORD_W - OFF_W){insn[OFF_W-1]}}, insn[OFF_W-1:0]};
                        if (!word_known[ea % MEM_DEPTH])
                            issue_command(CMD_LOAD, 16'(ea % MEM_DEPTH), $urandom);
                    end
                    issue_command(CMD_EXEC, 16'($urandom), $urandom);
                end else if (pick < 70) begin
                    if ($urandom_range(0, 1) == 0)
                        issue_command(CMD_LOAD, cur_pc + 16'($urandom_range(0, 7)),
                                      random_instruction());
                    else
                        issue_command(CMD_LOAD, 16'($urandom), $urandom);
                end else if (pick < 85) begin
                    issue_command(CMD_READ_MEM,
                                  known_addrs[$urandom_range(0, known_addrs.size() - 1)],
                                  $urandom);
                end else begin
                    issue_command(CMD_READ_REG, 16'($urandom), $urandom);
                end
            end
        end

        // Closing sequence: branch to the top address so the next pc wraps
        // to zero, then halt there, then show that executes do nothing while
        // the other commands keep working.
        hop = 16'hFFFF - cur_pc - 16'd1;
        issue_command(CMD_LOAD, cur_pc, encode(OP_BEQ, 3'd0, 3'd0, hop));
        issue_command(CMD_EXEC, 16'($urandom), $urandom);
        issue_command(CMD_LOAD, 16'hFFFF,
                      encode(OP_NOOP, 3'($urandom), 3'($urandom), 16'($urandom)));
        issue_command(CMD_EXEC, 16'($urandom), $urandom);
        issue_command(CMD_LOAD, 16'h0000,
                      encode(OP_HALT, 3'($urandom), 3'($urandom), 16'($urandom))
                      | ($urandom & 32'hFE00_0000));
        issue_command(CMD_EXEC, 16'($urandom), $urandom);
        issue_command(CMD_EXEC, 16'($urandom), $urandom);
        issue_command(CMD_EXEC, 16'($urandom), $urandom);
        issue_command(CMD_READ_REG, 16'($urandom), $urandom);
        issue_command(CMD_LOAD, 16'h4321, $urandom);
        issue_command(CMD_READ_MEM, 16'h4321, $urandom);
        issue_command(CMD_READ_MEM, 16'h0000, $urandom);
        i_s_tvalid <= 1'b0;

        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/eowm_pkg.sv
rtl/eowm_rf.sv
rtl/eight_opcode_word_machine_core.sv
rtl/eowm_chk.sv
test/tb.sv
